// File: rtl/core/pal_pkg.sv
package pal_pkg;

  localparam int unsigned DEPTH_DEF = 128;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned CAP_W     = 8;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned FIDX_W    = 7;
  localparam int unsigned LEN_W     = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic ins_en;
    logic del_en;
    logic srch_mode;
  } cell_cmd_t;

endpackage

// File: rtl/core/pal_req_if.sv
interface pal_req_if;
  logic                                valid;
  logic                                ready;
  logic [pal_pkg::OP_W-1:0]            op;
  logic [pal_pkg::POS_W-1:0]           position;
  logic signed [pal_pkg::DATA_W-1:0]   item_value;

  modport source (output valid, output op, output position, output item_value, input ready);
  modport sink (input valid, input op, input position, input item_value, output ready);
endinterface

// File: rtl/core/pal_rsp_if.sv
interface pal_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [pal_pkg::STAT_W-1:0]          status;
  logic signed [pal_pkg::DATA_W-1:0]   read_value;
  logic [pal_pkg::FIDX_W-1:0]          found_index;
  logic [pal_pkg::LEN_W-1:0]           list_length;

  modport source (output valid, output status, output read_value, output found_index,
                  output list_length, input ready);
  modport sink (input valid, input status, input read_value, input found_index,
                input list_length, output ready);
endinterface

// File: rtl/core/pal_cell.sv
module pal_cell #(
  parameter int unsigned DEPTH = pal_pkg::DEPTH_DEF,
  parameter int unsigned INDEX = 0,
  localparam int unsigned IDX_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  pal_pkg::cell_cmd_t          cmd_i,
  input  logic [IDX_W-1:0]            pos_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [pal_pkg::DATA_W-1:0]  key_i,
  input  logic [pal_pkg::DATA_W-1:0]  left_val_i,
  input  logic [pal_pkg::DATA_W-1:0]  right_val_i,
  output logic [pal_pkg::DATA_W-1:0]  val_o,
  input  logic                        prb_found_i,
  input  logic [IDX_W-1:0]            prb_idx_i,
  input  logic [pal_pkg::DATA_W-1:0]  prb_val_i,
  output logic                        prb_found_o,
  output logic [IDX_W-1:0]            prb_idx_o,
  output logic [pal_pkg::DATA_W-1:0]  prb_val_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic [pal_pkg::DATA_W-1:0] val_d, val_q;
  logic                       prb_found_d, prb_found_q;
  logic [IDX_W-1:0]           prb_idx_d, prb_idx_q;
  logic [pal_pkg::DATA_W-1:0] prb_val_d, prb_val_q;
  logic                       in_list;
  logic                       local_hit;

  assign in_list   = MY_CNT < count_i;
  assign local_hit = cmd_i.srch_mode ? (in_list && (val_q == key_i)) : (MY_IDX == pos_i);

  // shift up on insert, down on delete
  always_comb begin
    val_d = val_q;
    if (cmd_i.ins_en) begin
      if (MY_IDX == pos_i) begin
        val_d = key_i;
      end else if (MY_IDX > pos_i) begin
        val_d = left_val_i;
      end
    end else if (cmd_i.del_en && (MY_IDX >= pos_i)) begin
      val_d = right_val_i;
    end
  end

  // probe keeps the lowest hit seen so far
  always_comb begin
    if (prb_found_i) begin
      prb_found_d = 1'b1;
      prb_idx_d   = prb_idx_i;
      prb_val_d   = prb_val_i;
    end else begin
      prb_found_d = local_hit;
      prb_idx_d   = MY_IDX;
      prb_val_d   = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    prb_found_q <= prb_found_d;
    prb_idx_q   <= prb_idx_d;
    prb_val_q   <= prb_val_d;
  end

  assign val_o       = val_q;
  assign prb_found_o = prb_found_q;
  assign prb_idx_o   = prb_idx_q;
  assign prb_val_o   = prb_val_q;

endmodule

// File: rtl/core/positional_array_list.sv
// insert, clear and unused codes go straight from idle to the finish state, where the
// registered result is committed once the response slot is free; search, get and delete
// first pass a scan state while the match probe passes down the whole cell chain
// one request at a time: ready is high only in idle, until the last request has committed
// reset: empty list, capacity limit 128, entry storage undefined until written
module positional_array_list #(
  parameter int unsigned DEPTH = pal_pkg::DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pal_pkg::CAP_W-1:0] cfg_wdata_i,
  pal_req_if.sink                   req_i,
  pal_rsp_if.source                 rsp_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W;
  localparam logic [IDX_W-1:0] LAST_SCAN = IDX_W'(DEPTH - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                   state_d, state_q;
  logic [IDX_W-1:0]             scan_cnt_d, scan_cnt_q;
  logic [pal_pkg::OP_W-1:0]     op_q;
  logic [pal_pkg::POS_W-1:0]    pos_q;
  logic [pal_pkg::DATA_W-1:0]   key_q;
  logic [CNT_W-1:0]             count_d, count_q;
  logic [pal_pkg::CAP_W-1:0]    cap_q;

  logic                         rsp_valid_q;
  logic [pal_pkg::STAT_W-1:0]   status_d, status_q;
  logic [pal_pkg::DATA_W-1:0]   rdval_d, rdval_q;
  logic [pal_pkg::FIDX_W-1:0]   fidx_d, fidx_q;
  logic [pal_pkg::LEN_W-1:0]    len_q;

  logic                         accept;
  logic                         commit;
  logic                         scan_op;
  logic [CMP_W-1:0]             cap_ext, depth_ext, cap_now, count_ext, pos_ext, ins_pos;
  logic                         full;
  logic                         in_range;
  logic                         ins_ok, del_ok;
  logic [IDX_W-1:0]             cell_pos;
  pal_pkg::cell_cmd_t           cmd;

  logic [pal_pkg::DATA_W-1:0]   val_w     [DEPTH];
  logic [pal_pkg::DATA_W-1:0]   left_w    [DEPTH];
  logic [pal_pkg::DATA_W-1:0]   right_w   [DEPTH];
  logic                         pfound_w  [DEPTH];
  logic [IDX_W-1:0]             pidx_w    [DEPTH];
  logic [pal_pkg::DATA_W-1:0]   pval_w    [DEPTH];
  logic                         pfound_in [DEPTH];
  logic [IDX_W-1:0]             pidx_in   [DEPTH];
  logic [pal_pkg::DATA_W-1:0]   pval_in   [DEPTH];

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign commit      = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_o.ready);
  assign scan_op     = (req_i.op == pal_pkg::OP_SEARCH) || (req_i.op == pal_pkg::OP_GET) ||
                       (req_i.op == pal_pkg::OP_DELETE);

  assign cap_ext   = CMP_W'(cap_q);
  assign depth_ext = CMP_W'(DEPTH);
  assign cap_now   = (cap_ext < depth_ext) ? cap_ext : depth_ext;
  assign count_ext = CMP_W'(count_q);
  assign pos_ext   = CMP_W'(pos_q);
  assign full      = count_ext >= cap_now;
  assign in_range  = pos_ext < count_ext;
  assign ins_pos   = (pos_ext > count_ext) ? count_ext : pos_ext;
  assign cell_pos  = (op_q == pal_pkg::OP_INSERT) ? IDX_W'(ins_pos) : IDX_W'(pos_ext);

  // sequencing
  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    case (state_q)
      ST_IDLE: begin
        scan_cnt_d = '0;
        if (accept) begin
          state_d = scan_op ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_q == LAST_SCAN) begin
          state_d = ST_FINISH;
        end else begin
          scan_cnt_d = scan_cnt_q + IDX_W'(1);
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result and length update
  always_comb begin
    status_d = pal_pkg::STAT_OK;
    rdval_d  = '0;
    fidx_d   = '0;
    count_d  = count_q;
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    case (op_q)
      pal_pkg::OP_INSERT: begin
        if (full) begin
          status_d = pal_pkg::STAT_FULL;
        end else begin
          ins_ok  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      pal_pkg::OP_DELETE: begin
        if (!in_range) begin
          status_d = pal_pkg::STAT_RANGE;
        end else begin
          del_ok  = 1'b1;
          rdval_d = pval_w[DEPTH-1];
          count_d = count_q - CNT_W'(1);
        end
      end
      pal_pkg::OP_SEARCH: begin
        if (pfound_w[DEPTH-1]) begin
          fidx_d = pal_pkg::FIDX_W'(pidx_w[DEPTH-1]);
        end else begin
          status_d = pal_pkg::STAT_NOTFOUND;
        end
      end
      pal_pkg::OP_GET: begin
        if (!in_range) begin
          status_d = pal_pkg::STAT_RANGE;
        end else begin
          rdval_d = pval_w[DEPTH-1];
        end
      end
      pal_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign cmd.ins_en    = commit && ins_ok;
  assign cmd.del_en    = commit && del_ok;
  assign cmd.srch_mode = (op_q == pal_pkg::OP_SEARCH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_cnt_q  <= '0;
      count_q     <= '0;
      cap_q       <= pal_pkg::CAP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (commit) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.op;
      pos_q <= req_i.position;
      key_q <= req_i.item_value;
    end
    if (commit) begin
      status_q <= status_d;
      rdval_q  <= rdval_d;
      fidx_q   <= fidx_d;
      len_q    <= pal_pkg::LEN_W'(count_d);
    end
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_w[i]    = key_q;
      assign pfound_in[i] = 1'b0;
      assign pidx_in[i]   = '0;
      assign pval_in[i]   = '0;
    end else begin : g_body
      assign left_w[i]    = val_w[i-1];
      assign pfound_in[i] = pfound_w[i-1];
      assign pidx_in[i]   = pidx_w[i-1];
      assign pval_in[i]   = pval_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w[i] = val_w[i];
    end else begin : g_mid
      assign right_w[i] = val_w[i+1];
    end

    pal_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .pos_i       (cell_pos),
      .count_i     (count_q),
      .key_i       (key_q),
      .left_val_i  (left_w[i]),
      .right_val_i (right_w[i]),
      .val_o       (val_w[i]),
      .prb_found_i (pfound_in[i]),
      .prb_idx_i   (pidx_in[i]),
      .prb_val_i   (pval_in[i]),
      .prb_found_o (pfound_w[i]),
      .prb_idx_o   (pidx_w[i]),
      .prb_val_o   (pval_w[i])
    );
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.read_value  = rdval_q;
  assign rsp_o.found_index = fidx_q;
  assign rsp_o.list_length = len_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list length above depth");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_en |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (op_q == pal_pkg::OP_CLEAR)) |=> count_q == '0)
    else $error("clear left entries");

  a_commit_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> rsp_valid_q)
    else $error("finished request without result");

endmodule
